// ===== sv/dgs_pkg.sv =====
// Shared constants, command codes and status struct for the direction grid splatter.
// Used by dgs_ctrl, dgs_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
package dgs_pkg;
  localparam int GRID_DIM  = 64;
  localparam int CELL_W    = 6;            // bits of a column or row index
  localparam int CAND_W    = CELL_W + 1;   // holds 0 .. GRID_DIM
  localparam int ADDR_W    = 2 * CELL_W;
  localparam int COLOR_W   = 16;
  localparam int WORD_W    = 3 * COLOR_W;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLR_STEP,
    CMD_LOAD,
    CMD_READ,
    CMD_SQ,
    CMD_TRY_A,
    CMD_TRY_M,
    CMD_TRY_C,
    CMD_SPLAT_INIT,
    CMD_SPLAT_STEP
  } cmd_t;

  typedef struct packed {
    logic clr_done;    // last cell of the clearing pass is being written
    logic sq_last;     // last square accumulation step
    logic sq_zero;     // squared length is zero
    logic trial_last;  // last search trial of the last axis
    logic off_grid;    // centre cell lies outside the grid
    logic splat_done;  // last cell of the square is being written
  } status_t;
endpackage

// ===== sv/direction_grid_splatter.sv =====
// Top level of the direction grid splatter: joins controller and datapath.
// Depends on dgs_pkg, dgs_ctrl and dgs_datapath.
//
// Use: drive the item fields with start high; the transfer happens at an edge
// where start is high and busy is low. mode 1 reads one cell: the colour on
// out_red/out_green/out_blue is registered together with the rise of valid;
// busy is high for 1 cycle, and the next transfer can follow once it falls.
// mode 0 splats: no result.
// A splat runs the squared length accumulation, a length check, the exact cell
// search (7 trials per axis, each in S_TRY_A, S_TRY_M and S_TRY_C through the
// shared multiplier), the centre check and setup and then max(1, (2S)^2) cell
// writes, one cell per cycle, cells off the grid not written: busy stays high
// until the last cell. A zero vector ends after the length check, a centre off
// the grid after the centre check.
// At reset the 4096-cell memory is cleared one cell per cycle: busy stays high
// until the clearing pass ends, before the first transfer.
// The receiver cannot stall; valid marks each result once, and the colour stays until the next read.
`timescale 1ns / 1ps
module direction_grid_splatter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic signed [15:0]          dir_x,
  input  logic signed [15:0]          dir_y,
  input  logic signed [15:0]          dir_z,
  input  logic [dgs_pkg::COLOR_W-1:0] red,
  input  logic [dgs_pkg::COLOR_W-1:0] green,
  input  logic [dgs_pkg::COLOR_W-1:0] blue,
  input  logic [4:0]                  splat_radius,
  input  logic [dgs_pkg::CELL_W-1:0]  read_col,
  input  logic [dgs_pkg::CELL_W-1:0]  read_row,
  output logic                        valid,
  output logic [dgs_pkg::COLOR_W-1:0] out_red,
  output logic [dgs_pkg::COLOR_W-1:0] out_green,
  output logic [dgs_pkg::COLOR_W-1:0] out_blue
);
  import dgs_pkg::*;

  cmd_t    cmd;
  status_t status;

  dgs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(mode),
    .status(status), .cmd(cmd), .busy(busy), .valid(valid)
  );

  dgs_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .red(red), .green(green), .blue(blue),
    .splat_radius(splat_radius), .read_col(read_col), .read_row(read_row),
    .status(status),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );
endmodule

// ===== sv/dgs_ctrl.sv =====
// Controller state machine: sequences clear, read, length, cell search and splat.
// Drives dgs_datapath through cmd_t commands and reads its status_t; uses dgs_pkg.
`timescale 1ns / 1ps
module dgs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             mode,
  input  dgs_pkg::status_t status,
  output dgs_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             valid
);
  import dgs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_SQ, S_LEN, S_TRY_A, S_TRY_M, S_TRY_C,
    S_CHECK, S_SPLAT_INIT, S_SPLAT
  } state_t;

  state_t state;

  // issue the command of the current state
  always_comb begin
    unique case (state)
      S_CLEAR:      cmd = CMD_CLR_STEP;
      S_IDLE:       cmd = start ? CMD_LOAD : CMD_NONE;
      S_READ:       cmd = CMD_READ;
      S_SQ:         cmd = CMD_SQ;
      S_TRY_A:      cmd = CMD_TRY_A;
      S_TRY_M:      cmd = CMD_TRY_M;
      S_TRY_C:      cmd = CMD_TRY_C;
      S_SPLAT_INIT: cmd = CMD_SPLAT_INIT;
      S_SPLAT:      cmd = CMD_SPLAT_STEP;
      default:      cmd = CMD_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);

  // hold state and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_CLEAR: if (status.clr_done) state <= S_IDLE;
        S_IDLE:  if (start) state <= mode ? S_READ : S_SQ;
        S_READ: begin
          valid <= 1'b1;
          state <= S_IDLE;
        end
        S_SQ:    if (status.sq_last) state <= S_LEN;
        S_LEN:   state <= status.sq_zero ? S_IDLE : S_TRY_A;
        S_TRY_A: state <= S_TRY_M;
        S_TRY_M: state <= S_TRY_C;
        S_TRY_C: state <= status.trial_last ? S_CHECK : S_TRY_A;
        S_CHECK: state <= status.off_grid ? S_IDLE : S_SPLAT_INIT;
        S_SPLAT_INIT: state <= S_SPLAT;
        S_SPLAT: if (status.splat_done) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_valid_after_read: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(state == S_READ)) else $error("strobe without read");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("transfer did not raise busy");
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("strobe longer than one cycle");
endmodule

// ===== sv/dgs_datapath.sv =====
// Datapath: input registers, shared multiplier, exact cell search, splat counters
// and the cell memory. Driven by dgs_ctrl commands; uses dgs_pkg.
`timescale 1ns / 1ps
module dgs_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  dgs_pkg::cmd_t                  cmd,
  input  logic signed [15:0]             dir_x,
  input  logic signed [15:0]             dir_y,
  input  logic signed [15:0]             dir_z,
  input  logic [dgs_pkg::COLOR_W-1:0]    red,
  input  logic [dgs_pkg::COLOR_W-1:0]    green,
  input  logic [dgs_pkg::COLOR_W-1:0]    blue,
  input  logic [4:0]                     splat_radius,
  input  logic [dgs_pkg::CELL_W-1:0]     read_col,
  input  logic [dgs_pkg::CELL_W-1:0]     read_row,
  output dgs_pkg::status_t               status,
  output logic [dgs_pkg::COLOR_W-1:0]    out_red,
  output logic [dgs_pkg::COLOR_W-1:0]    out_green,
  output logic [dgs_pkg::COLOR_W-1:0]    out_blue
);
  import dgs_pkg::*;

  logic [WORD_W-1:0] mem [GRID_DIM*GRID_DIM];

  logic signed [15:0] x, y, z;
  logic [WORD_W-1:0]  color;
  logic [4:0]         s;
  logic [ADDR_W-1:0]  rd_addr, clr_addr;
  logic               rd_ok;
  logic [WORD_W-1:0]  rdata;

  logic [1:0]  sq_idx;
  logic [31:0] sqr, sq, xsq, ysq;
  logic        axis;
  logic [2:0]  bitidx;
  logic [CAND_W-1:0] c, col;
  logic [15:0] asq;
  logic        a_pos, t_ok;
  logic [47:0] prod;
  logic signed [5:0] dc, dr, lo, hi;

  // candidate of this trial and its signed offset 2t - GRID_DIM
  logic [CAND_W-1:0]  t;
  logic signed [8:0]  a;
  logic [7:0]         a_mag;
  assign t     = c | CAND_W'(1 << bitidx);
  assign a     = $signed({1'b0, t, 1'b0}) - 9'(GRID_DIM);
  assign a_mag = a[8] ? 8'(-a) : a[7:0];

  // square of one component magnitude
  logic signed [15:0] comp_sel;
  logic [15:0]        comp_mag;
  always_comb begin
    unique case (sq_idx)
      2'd0:    comp_sel = x;
      2'd1:    comp_sel = y;
      2'd2:    comp_sel = z;
      default: comp_sel = '0;
    endcase
  end
  assign comp_mag = comp_sel[15] ? 16'(-comp_sel) : comp_sel;

  // shared multiplier: squares of components, then a^2 * |d|^2
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;
  assign mul_a = (cmd == CMD_SQ) ? {16'b0, comp_mag} : sq;
  assign mul_b = (cmd == CMD_SQ) ? comp_mag : asq;
  assign mul_p = mul_a * mul_b;

  // exact test a * |d| <= GRID_DIM * comp
  logic signed [15:0] comp;
  logic [47:0] rhs;
  logic        b_neg, pred;
  assign comp  = axis ? y : x;
  assign b_neg = comp[15];
  assign rhs   = {4'b0, (axis ? ysq : xsq), 12'b0};
  always_comb begin
    priority if (!a_pos && !b_neg) pred = 1'b1;
    else if (a_pos && b_neg)        pred = 1'b0;
    else if (a_pos)                 pred = (prod <= rhs);
    else                            pred = (prod >= rhs);
  end

  logic [CAND_W-1:0] c_new;
  assign c_new = (t_ok && pred) ? t : c;

  // splat target cell
  logic signed [7:0] tcol, trow;
  logic              t_in;
  assign tcol = $signed({2'b0, col[CELL_W-1:0]}) + 8'(dc);
  assign trow = $signed({2'b0, c[CELL_W-1:0]}) + 8'(dr);
  assign t_in = (tcol[7:6] == 2'b00) && (trow[7:6] == 2'b00);

  assign status.clr_done   = (clr_addr == '1);
  assign status.sq_last    = (sq_idx == 2'd3);
  assign status.sq_zero    = (sq == '0);
  assign status.trial_last = axis && (bitidx == '0);
  assign status.off_grid   = col[CELL_W] | c[CELL_W];
  assign status.splat_done = (dc == hi) && (dr == hi);

  // advance the clearing address from zero after reset
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd == CMD_CLR_STEP) clr_addr <= clr_addr + 1'b1;
  end

  // advance registers per command
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        x <= dir_x; y <= dir_y; z <= dir_z;
        color   <= {red, green, blue};
        s       <= splat_radius;
        rd_addr <= {read_row, read_col};
        rd_ok   <= (32'(read_col) < GRID_DIM) && (32'(read_row) < GRID_DIM);
        sq_idx  <= '0; sq <= '0; sqr <= '0;
        axis <= 1'b0; c <= '0; bitidx <= 3'(CAND_W - 1);
      end
      CMD_SQ: begin
        sqr <= mul_p[31:0];
        sq  <= sq + sqr;
        if (sq_idx == 2'd1) xsq <= sqr;
        if (sq_idx == 2'd2) ysq <= sqr;
        sq_idx <= sq_idx + 1'b1;
      end
      CMD_TRY_A: begin
        asq   <= 16'(a_mag) * 16'(a_mag);
        a_pos <= !a[8] && (a != '0);
        t_ok  <= (32'(t) <= GRID_DIM);
      end
      CMD_TRY_M: prod <= mul_p;
      CMD_TRY_C: begin
        if (bitidx == '0 && !axis) begin
          col    <= c_new;
          c      <= '0;
          axis   <= 1'b1;
          bitidx <= 3'(CAND_W - 1);
        end else begin
          c      <= c_new;
          bitidx <= bitidx - 1'b1;
        end
      end
      CMD_SPLAT_INIT: begin
        lo <= (s == '0) ? 6'sd0 : -$signed({1'b0, s});
        hi <= (s == '0) ? 6'sd0 : $signed({1'b0, s}) - 6'sd1;
        dc <= (s == '0) ? 6'sd0 : -$signed({1'b0, s});
        dr <= (s == '0) ? 6'sd0 : -$signed({1'b0, s});
      end
      CMD_SPLAT_STEP: begin
        if (dr == hi) begin
          dr <= lo;
          dc <= dc + 6'sd1;
        end else begin
          dr <= dr + 6'sd1;
        end
      end
      default: ;
    endcase
  end

  // cell memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd == CMD_CLR_STEP) mem[clr_addr] <= '0;
    else if (cmd == CMD_SPLAT_STEP && t_in)
      mem[{trow[CELL_W-1:0], tcol[CELL_W-1:0]}] <= color;
    if (cmd == CMD_READ) rdata <= rd_ok ? mem[rd_addr] : '0;
  end

  assign out_red   = rdata[3*COLOR_W-1:2*COLOR_W];
  assign out_green = rdata[2*COLOR_W-1:COLOR_W];
  assign out_blue  = rdata[COLOR_W-1:0];
endmodule

// ===== tb/direction_grid_splatter_chk.sv =====
// Checker for the direction grid splatter: keeps its own copy of the grid,
// predicts read colours and compares them with the valid-marked outputs.
// Depends on dgs_pkg; instantiated by direction_grid_splatter_tb.
`timescale 1ns / 1ps
module direction_grid_splatter_chk (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        mode,
  input  logic signed [15:0]          dir_x,
  input  logic signed [15:0]          dir_y,
  input  logic signed [15:0]          dir_z,
  input  logic [dgs_pkg::COLOR_W-1:0] red,
  input  logic [dgs_pkg::COLOR_W-1:0] green,
  input  logic [dgs_pkg::COLOR_W-1:0] blue,
  input  logic [4:0]                  splat_radius,
  input  logic [dgs_pkg::CELL_W-1:0]  read_col,
  input  logic [dgs_pkg::CELL_W-1:0]  read_row,
  input  logic                        valid,
  input  logic [dgs_pkg::COLOR_W-1:0] out_red,
  input  logic [dgs_pkg::COLOR_W-1:0] out_green,
  input  logic [dgs_pkg::COLOR_W-1:0] out_blue,
  output int                          fail_count,
  output int                          pending,
  output int                          reads_seen
);
  import dgs_pkg::*;

  logic [WORD_W-1:0] grid_model [GRID_DIM*GRID_DIM];
  logic [WORD_W-1:0] colors_due [$];

  // True when a * sqrt(sq) <= b, exactly.
  function automatic bit root_scaled_le(longint a, longint b, longint unsigned sq);
    longint unsigned ma, mb, lhs, rhs;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    lhs = ma * ma * sq;
    rhs = mb * mb;
    if (a <= 0 && b >= 0) return 1;
    if (a > 0 && b < 0) return 0;
    if (a > 0) return lhs <= rhs;
    return lhs >= rhs;
  endfunction

  // Largest cell c in 0..GRID_DIM with (2c - GRID_DIM) * L <= GRID_DIM * comp.
  function automatic int project_axis(int comp, longint unsigned sq);
    longint b;
    b = longint'(GRID_DIM) * comp;
    for (int c = GRID_DIM; c > 0; c--)
      if (root_scaled_le(2 * c - GRID_DIM, b, sq)) return c;
    return 0;
  endfunction

  task automatic paint_cell(int col, int row, logic [WORD_W-1:0] w);
    if (col >= 0 && row >= 0 && col < GRID_DIM && row < GRID_DIM)
      grid_model[row*GRID_DIM+col] = w;
  endtask

  task automatic apply_splat();
    longint unsigned sq;
    int col, row, s;
    logic [WORD_W-1:0] w;
    sq = longint'(dir_x) * dir_x + longint'(dir_y) * dir_y + longint'(dir_z) * dir_z;
    if (sq == 0) return;
    col = project_axis(dir_x, sq);
    row = project_axis(dir_y, sq);
    if (col >= GRID_DIM || row >= GRID_DIM) return;
    w = {red, green, blue};
    s = splat_radius;
    paint_cell(col, row, w);
    for (int dc = -s; dc < s; dc++)
      for (int dr = -s; dr < s; dr++)
        paint_cell(col + dc, row + dr, w);
  endtask

  assign pending = colors_due.size();

  initial begin
    fail_count = 0;
    reads_seen = 0;
    foreach (grid_model[i]) grid_model[i] = '0;
  end

  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (!rst) begin
      // Check a result against the oldest waiting colour.
      if (valid) begin
        reads_seen++;
        if (colors_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h %h %h",
                                         out_red, out_green, out_blue);
        end else begin
          want = colors_due.pop_front();
          if ({out_red, out_green, out_blue} !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected r=%h g=%h b=%h got r=%h g=%h b=%h",
                       want[47:32], want[31:16], want[15:0],
                       out_red, out_green, out_blue);
          end
        end
      end
      // Predict each accepted transfer.
      if (start && !busy) begin
        if (mode) begin
          if (read_col < GRID_DIM && read_row < GRID_DIM)
            colors_due.push_back(grid_model[read_row*GRID_DIM+read_col]);
          else
            colors_due.push_back('0);
        end else begin
          apply_splat();
        end
      end
    end
  end
endmodule

// ===== tb/direction_grid_splatter_tb.sv =====
// Top of the direction grid splatter testbench: clock, reset, stimulus, verdict.
// Depends on dgs_pkg, direction_grid_splatter and direction_grid_splatter_chk.
`timescale 1ns / 1ps
module direction_grid_splatter_tb;
  import dgs_pkg::*;

  localparam int RANDOM_ITEMS = 1130;
  localparam int STALL_LIMIT  = 20000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, valid;
  logic mode = 0;
  logic signed [15:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic [COLOR_W-1:0] red = 0, green = 0, blue = 0;
  logic [4:0] splat_radius = 0;
  logic [CELL_W-1:0] read_col = 0, read_row = 0;
  logic [COLOR_W-1:0] out_red, out_green, out_blue;
  int fail_count, pending, reads_seen;
  int idle_cycles = 0;
  int splats_sent = 0;
  int reads_sent = 0;

  always #1 clk = ~clk;

  direction_grid_splatter u_dut (.*);
  direction_grid_splatter_chk u_chk (.*);

  // Count cycles with no transfer and no result; stop a hung run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("** direction_grid_splatter: FAILED **");
      $finish;
    end
  end

  // Drop start for a random gap, then hold one item until the transfer.
  task automatic send_item(bit m, int x, int y, int z, int r, int g, int b,
                           int s, int c, int w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    mode <= m; dir_x <= 16'(x); dir_y <= 16'(y); dir_z <= 16'(z);
    red <= COLOR_W'(r); green <= COLOR_W'(g); blue <= COLOR_W'(b);
    splat_radius <= 5'(s); read_col <= CELL_W'(c); read_row <= CELL_W'(w);
    start <= 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (m) reads_sent++; else splats_sent++;
  endtask

  task automatic splat(int x, int y, int z, int s);
    send_item(0, x, y, z, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), s, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  task automatic read_cell(int c, int w);
    send_item(1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(0, 31), c, w);
  endtask

  // Small radius mostly; a few large squares.
  function automatic int pick_radius();
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) return $urandom_range(16, 31);
    if (k < 30) return 0;
    return $urandom_range(1, 4);
  endfunction

  // Direction component: full range, extreme, zero or small.
  function automatic int pick_comp();
    case ($urandom_range(0, 4))
      0: return $signed(16'($urandom));
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      2: return 0;
      default: return $signed(16'($urandom_range(0, 40))) - 20;
    endcase
  endfunction

  initial begin
    int m;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: axes, zero vector, extremes, edge reads.
    read_cell(0, 0);
    read_cell(63, 63);
    splat(0, 0, 0, 5);
    splat(0, 0, 1, 0);
    read_cell(32, 32);
    splat(1, 0, 0, 3);
    splat(0, 1, 0, 3);
    read_cell(63, 32);
    splat(-32768, 0, 0, 2);
    read_cell(0, 32);
    splat(0, -32768, 0, 31);
    splat(32767, 32767, 32767, 1);
    splat(-32768, -32768, -32768, 1);
    read_cell(0, 0);
    splat(-1, -1, 0, 31);
    read_cell(63, 0);
    read_cell(0, 63);
    splat(3, -4, 0, 4);
    read_cell(40, 12);
    splat(-32768, 32767, 0, 0);
    send_item(1, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31, 6'h3F, 6'h3F);
    send_item(0, 7, 9, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2, 0, 0);
    read_cell(32, 32);

    // Random: splats mixed with reads, most of the reads near the grid centre.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      m = $urandom_range(0, 99);
      if (m < 45) splat(pick_comp(), pick_comp(), pick_comp(), pick_radius());
      else if (m < 90) read_cell($urandom_range(20, 44), $urandom_range(20, 44));
      else read_cell($urandom_range(0, 63), $urandom_range(0, 63));
    end
    start <= 0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d splats (radius 0 to 31, zero and axis vectors) and %0d reads",
             splats_sent, reads_sent);
    $display("%0d results checked, %0d mismatches", reads_seen, fail_count);
    if (fail_count == 0) $display("** direction_grid_splatter: PASSED **");
    else $display("** direction_grid_splatter: FAILED **");
    $finish;
  end
endmodule
